// ----- rtl/dbcs_pkg.sv -----
`default_nettype none

package dbcs_pkg;

    // Word format: signed Q16.16.
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * DATA_W;
    // Field plus rounded product, before saturation.
    localparam int WIDE_W    = PROD_W - FRAC_W + 1;

    localparam int DEF_MAX_X = 256;
    localparam int DEF_MAX_Y = 256;
    localparam int MAX_Z     = 4096;
    localparam int Z_W       = 12;

    localparam int XY_SIZE_W = 9;
    localparam int Z_SIZE_W  = 13;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_X,
        CFG_GRID_Y,
        CFG_GRID_Z,
        CFG_COEF_X,
        CFG_COEF_Y,
        CFG_COEF_Z
    } t_cfg_idx;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        t_word err_value;
        t_word field_x;
        t_word field_y;
        t_word field_z;
    } t_in_item;

    typedef struct packed {
        t_word new_field_x;
        t_word new_field_y;
        t_word new_field_z;
        logic  last_voxel;
    } t_out_item;

    typedef struct packed {
        logic clean;
        logic last;
    } t_voxel_flags;

    typedef struct packed {
        logic diff_en;
        logic prod_en;
        logic out_en;
    } t_pipe_en;

    // Clamp a wide two's complement value to the word range.
    function automatic t_word sat_word(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] upper;
        t_word                  res;
        upper = v[WIDE_W-1:DATA_W-1];
        if ((&upper) || !(|upper)) begin
            res = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dbcs_ram.sv -----
`default_nettype none

module dbcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read-first: a read of the entry written at the same edge returns the old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/dbcs_scan.sv -----
`default_nettype none

module dbcs_scan
    import dbcs_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]               i_cfg_index,
    input  wire logic [DATA_W-1:0]                  i_cfg_data,
    input  wire logic                               i_accept,
    output logic      [$clog2(MAX_X)-1:0]           o_row_addr,
    output logic      [$clog2(MAX_X)+$clog2(MAX_Y)-1:0] o_plane_addr,
    output t_voxel_flags                            o_flags,
    output t_word                                   o_coef_x,
    output t_word                                   o_coef_y,
    output t_word                                   o_coef_z
);

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);

    // A size of zero counts as one, a size above the maximum is clamped.
    function automatic logic [XW-1:0] last_x(input logic [XY_SIZE_W-1:0] s);
        logic [XW-1:0] res;
        if (s == '0) begin
            res = '0;
        end else if (32'(s) > MAX_X) begin
            res = XW'(MAX_X - 1);
        end else begin
            res = XW'(s - 1'b1);
        end
        return res;
    endfunction

    function automatic logic [YW-1:0] last_y(input logic [XY_SIZE_W-1:0] s);
        logic [YW-1:0] res;
        if (s == '0) begin
            res = '0;
        end else if (32'(s) > MAX_Y) begin
            res = YW'(MAX_Y - 1);
        end else begin
            res = YW'(s - 1'b1);
        end
        return res;
    endfunction

    function automatic logic [Z_W-1:0] last_z(input logic [Z_SIZE_W-1:0] s);
        logic [Z_W-1:0] res;
        if (s == '0) begin
            res = '0;
        end else if (32'(s) > MAX_Z) begin
            res = Z_W'(MAX_Z - 1);
        end else begin
            res = Z_W'(s - 1'b1);
        end
        return res;
    endfunction

    logic [XW-1:0]  r_last_x;
    logic [YW-1:0]  r_last_y;
    logic [Z_W-1:0] r_last_z;
    t_word          r_coef_x;
    t_word          r_coef_y;
    t_word          r_coef_z;

    logic [XW-1:0]  r_x;
    logic [YW-1:0]  r_y;
    logic [Z_W-1:0] r_z;
    logic [XW-1:0]  n_x;
    logic [YW-1:0]  n_y;
    logic [Z_W-1:0] n_z;
    logic           x_end;
    logic           y_end;
    logic           z_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
            r_last_z <= '0;
            r_coef_x <= '0;
            r_coef_y <= '0;
            r_coef_z <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GRID_X: r_last_x <= last_x(i_cfg_data[XY_SIZE_W-1:0]);
                CFG_GRID_Y: r_last_y <= last_y(i_cfg_data[XY_SIZE_W-1:0]);
                CFG_GRID_Z: r_last_z <= last_z(i_cfg_data[Z_SIZE_W-1:0]);
                CFG_COEF_X: r_coef_x <= i_cfg_data;
                CFG_COEF_Y: r_coef_y <= i_cfg_data;
                CFG_COEF_Z: r_coef_z <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A position at or past its last index wraps on the next advance.
    assign x_end = (r_x >= r_last_x);
    assign y_end = (r_y >= r_last_y);
    assign z_end = (r_z >= r_last_z);

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_z = r_z;
        if (!x_end) begin
            n_x = r_x + 1'b1;
        end else begin
            n_x = '0;
            if (!y_end) begin
                n_y = r_y + 1'b1;
            end else begin
                n_y = '0;
                n_z = z_end ? '0 : r_z + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end else if (i_accept) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_row_addr    = r_x;
    assign o_plane_addr  = {r_y, r_x};
    assign o_flags.clean = (r_x != '0) && (r_y != '0) && (r_z != '0);
    assign o_flags.last  = x_end && y_end && z_end;
    assign o_coef_x      = r_coef_x;
    assign o_coef_y      = r_coef_y;
    assign o_coef_z      = r_coef_z;

endmodule

`default_nettype wire

// ----- rtl/dbcs_lane.sv -----
`default_nettype none

module dbcs_lane
    import dbcs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire t_pipe_en i_en,
    input  wire logic     i_clean,
    input  wire t_word    i_err,
    input  wire t_word    i_nbr,
    input  wire t_word    i_field,
    input  wire t_word    i_coef,
    output t_word         o_result
);

    logic [DATA_W:0]   diff_full;
    logic [PROD_W-1:0] prod_full;
    logic [WIDE_W-1:0] total;

    t_word             r_diff;
    t_word             r_field2;
    logic              r_clean2;
    logic [PROD_W-1:0] r_prod;
    t_word             r_field3;
    logic              r_clean3;
    t_word             r_result;

    assign diff_full = {i_err[DATA_W-1], i_err} - {i_nbr[DATA_W-1], i_nbr};
    assign prod_full = r_diff * i_coef;

    // Rounding half up: the bit below the kept fraction enters as a carry.
    assign total = {{(WIDE_W-DATA_W){r_field3[DATA_W-1]}}, r_field3}
                 + {r_prod[PROD_W-1], r_prod[PROD_W-1:FRAC_W]}
                 + {{(WIDE_W-1){1'b0}}, r_prod[FRAC_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_en.diff_en) begin
            r_diff   <= sat_word({{(WIDE_W-DATA_W-1){diff_full[DATA_W]}}, diff_full});
            r_field2 <= i_field;
            r_clean2 <= i_clean;
        end
        if (i_en.prod_en) begin
            r_prod   <= prod_full;
            r_field3 <= r_field2;
            r_clean3 <= r_clean2;
        end
        if (i_en.out_en) begin
            r_result <= r_clean3 ? sat_word(total) : r_field3;
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/div_b_clean_stencil.sv -----
`default_nettype none

// Channel    Handshake                     Payload              Direction
// input      i_in_valid / o_in_ready       i_in_data  t_in_item  in
// output     o_out_valid / i_out_ready     o_out_data t_out_item out
// config     i_cfg_we                      i_cfg_index, i_cfg_data in
//
// The block takes one voxel transaction per cycle unless the pipeline stalls, and
// moves it through the difference, product and output registers. The line and
// plane stores are read and written at the same address in the cycle a voxel is
// accepted; their read-first behavior gives the neighbor error before it is overwritten, so no forwarding is needed.
// Reset clears positions, sizes, coefficients and the previous error; the stores
// are not cleared and need no clearing pass. Each pipeline stage holds only when
// the stage after it is full and stalled, so a waiting result does not block input.

module div_b_clean_stencil
    import dbcs_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DATA_W-1:0]    i_cfg_data
);

    localparam int XW = $clog2(MAX_X);
    localparam int YW = $clog2(MAX_Y);

    logic              accept;
    logic              out_free;
    logic              s3_free;
    logic              s2_free;
    logic              s1_free;
    t_pipe_en          pipe_en;

    logic [XW-1:0]     row_addr;
    logic [XW+YW-1:0]  plane_addr;
    t_voxel_flags      flags;
    t_word             coef_x;
    t_word             coef_y;
    t_word             coef_z;
    logic [DATA_W-1:0] row_rdata;
    logic [DATA_W-1:0] plane_rdata;
    t_word             res_x;
    t_word             res_y;
    t_word             res_z;

    // Valid bits of the accept stage, the difference and product stages and
    // the output register.
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic              r_out_valid;
    t_word             r_prev_error;

    // Payload of the accepted voxel while the store reads complete.
    t_in_item          r_s1_item;
    t_word             r_s1_prev;
    t_voxel_flags      r_s1_flags;
    logic              r_s2_last;
    logic              r_s3_last;
    logic              r_out_last;

    // Each stage may load when it is empty or when its successor moves on.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s3_free    = !r_v3 || out_free;
    assign s2_free    = !r_v2 || s3_free;
    assign s1_free    = !r_v1 || s2_free;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && s1_free;

    assign pipe_en.diff_en = s2_free;
    assign pipe_en.prod_en = s3_free;
    assign pipe_en.out_en  = out_free;

    dbcs_scan #(
        .MAX_X (MAX_X),
        .MAX_Y (MAX_Y)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .o_row_addr   (row_addr),
        .o_plane_addr (plane_addr),
        .o_flags      (flags),
        .o_coef_x     (coef_x),
        .o_coef_y     (coef_y),
        .o_coef_z     (coef_z)
    );

    // Line store: one error per x position, one row back.
    dbcs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 ** XW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (row_addr),
        .i_wdata (i_in_data.err_value),
        .i_re    (accept),
        .i_raddr (row_addr),
        .o_rdata (row_rdata)
    );

    // Plane store: one error per (x, y) position, one plane back.
    dbcs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (2 ** (XW + YW))
    ) u_plane_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (plane_addr),
        .i_wdata (i_in_data.err_value),
        .i_re    (accept),
        .i_raddr (plane_addr),
        .o_rdata (plane_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_error <= '0;
        end else begin
            if (s1_free) begin
                r_v1 <= accept;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (s3_free) begin
                r_v3 <= r_v2;
            end
            if (out_free) begin
                r_out_valid <= r_v3;
            end
            if (accept) begin
                r_prev_error <= i_in_data.err_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= i_in_data;
            r_s1_prev  <= r_prev_error;
            r_s1_flags <= flags;
        end
        if (s2_free) begin
            r_s2_last <= r_s1_flags.last;
        end
        if (s3_free) begin
            r_s3_last <= r_s2_last;
        end
        if (out_free) begin
            r_out_last <= r_s3_last;
        end
    end

    dbcs_lane u_lane_x (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_clean  (r_s1_flags.clean),
        .i_err    (r_s1_item.err_value),
        .i_nbr    (r_s1_prev),
        .i_field  (r_s1_item.field_x),
        .i_coef   (coef_x),
        .o_result (res_x)
    );

    dbcs_lane u_lane_y (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_clean  (r_s1_flags.clean),
        .i_err    (r_s1_item.err_value),
        .i_nbr    (row_rdata),
        .i_field  (r_s1_item.field_y),
        .i_coef   (coef_y),
        .o_result (res_y)
    );

    dbcs_lane u_lane_z (
        .i_clk    (i_clk),
        .i_en     (pipe_en),
        .i_clean  (r_s1_flags.clean),
        .i_err    (r_s1_item.err_value),
        .i_nbr    (plane_rdata),
        .i_field  (r_s1_item.field_z),
        .i_coef   (coef_z),
        .o_result (res_z)
    );

    assign o_out_valid            = r_out_valid;
    assign o_out_data.new_field_x = res_x;
    assign o_out_data.new_field_y = res_y;
    assign o_out_data.new_field_z = res_z;
    assign o_out_data.last_voxel  = r_out_last;

endmodule

`default_nettype wire

// ----- tb/div_b_clean_stencil_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the backward-difference cleaning stencil. A local
// predictor keeps its own copy of the previous error, the line and plane error
// stores and the raster position. It computes the expected cleaned field for
// every voxel transaction accepted on the input channel. A checker process
// compares every output transaction, field by field, with the oldest entry of
// the expected queue.
module div_b_clean_stencil_tb;
    import dbcs_pkg::*;

    localparam int    CYCLE_LIMIT  = 200000;
    localparam int    DRAIN_CYCLES = 10;   // Comfortably above the pipeline latency.
    localparam int    HOLD_CYCLES  = 200;
    localparam t_word WORD_MAX     = 32'sh7fffffff;
    localparam t_word WORD_MIN     = 32'sh80000000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    t_in_item            in_data   = '0;
    logic                in_ready;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_item           out_data;
    logic                cfg_we    = 1'b0;
    t_cfg_idx            cfg_index = CFG_GRID_X;
    logic [DATA_W-1:0]   cfg_data  = '0;

    // Idling is on by default; the steady-stream test turns it off for a while.
    bit                  idle_en   = 1'b1;
    // Each increment of hold_req asks the receiver for one long hold-off.
    int                  hold_req  = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;
    int                  cycle_count = 0;
    int                  mismatches  = 0;

    // Expected output transactions, oldest first.
    t_out_item           expected_fields[$];

    // Predictor copy of the configuration registers, at their reset values.
    logic [XY_SIZE_W-1:0] size_x_q = 1;
    logic [XY_SIZE_W-1:0] size_y_q = 1;
    logic [Z_SIZE_W-1:0]  size_z_q = 1;
    t_word                coef_x_q = '0;
    t_word                coef_y_q = '0;
    t_word                coef_z_q = '0;

    // Predictor copy of the error history and the raster position.
    t_word                err_prev = '0;
    t_word                err_line  [DEF_MAX_X];
    t_word                err_plane [DEF_MAX_X * DEF_MAX_Y];
    int                   pos_x = 0;
    int                   pos_y = 0;
    int                   pos_z = 0;

    div_b_clean_stencil dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A size of zero counts as one; a size above the maximum is clamped.
    function automatic int eff_size(input int s, input int max_size);
        if (s == 0) return 1;
        if (s > max_size) return max_size;
        return s;
    endfunction

    function automatic int grid_voxels();
        return eff_size(size_x_q, DEF_MAX_X) * eff_size(size_y_q, DEF_MAX_Y)
            * eff_size(size_z_q, MAX_Z);
    endfunction

    function automatic t_word clamp_word(input longint v);
        if (v > longint'(WORD_MAX)) return WORD_MAX;
        if (v < longint'(WORD_MIN)) return WORD_MIN;
        return t_word'(v);
    endfunction

    // field + round(coef * sat(err - neighbor err)), where the product carries
    // 32 fraction bits and halves round toward plus infinity.
    function automatic t_word clean_component(input t_word field, input t_word coef,
                                              input t_word err, input t_word nbr_err);
        longint diff;
        longint prod;
        longint rounded;
        diff    = longint'(clamp_word(longint'(err) - longint'(nbr_err)));
        prod    = longint'(coef) * diff;
        rounded = (prod + 64'sd32768) >>> FRAC_W;
        return clamp_word(longint'(field) + rounded);
    endfunction

    // Computes the result of one voxel and advances the raster position.
    function automatic t_out_item predict_cleaned_voxel(input t_in_item v);
        t_out_item r;
        int        nx;
        int        ny;
        int        nz;
        int        plane_idx;
        bit        x_end;
        bit        y_end;
        bit        z_end;
        nx        = eff_size(size_x_q, DEF_MAX_X);
        ny        = eff_size(size_y_q, DEF_MAX_Y);
        nz        = eff_size(size_z_q, MAX_Z);
        plane_idx = pos_y * DEF_MAX_X + pos_x;
        r.new_field_x = v.field_x;
        r.new_field_y = v.field_y;
        r.new_field_z = v.field_z;
        // Only voxels away from the first row, column and plane are cleaned.
        if (pos_x >= 1 && pos_y >= 1 && pos_z >= 1) begin
            r.new_field_x = clean_component(v.field_x, coef_x_q, v.err_value, err_prev);
            r.new_field_y = clean_component(v.field_y, coef_y_q, v.err_value,
                                            err_line[pos_x]);
            r.new_field_z = clean_component(v.field_z, coef_z_q, v.err_value,
                                            err_plane[plane_idx]);
        end
        err_prev             = v.err_value;
        err_line[pos_x]      = v.err_value;
        err_plane[plane_idx] = v.err_value;
        // A position at or past its last index ends that axis, which also
        // covers positions left beyond a grid that shrank mid-way.
        x_end = (pos_x + 1 >= nx);
        y_end = (pos_y + 1 >= ny);
        z_end = (pos_z + 1 >= nz);
        r.last_voxel = x_end && y_end && z_end;
        if (!x_end) begin
            pos_x++;
        end else begin
            pos_x = 0;
            if (!y_end) begin
                pos_y++;
            end else begin
                pos_y = 0;
                pos_z = z_end ? 0 : pos_z + 1;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------

    // A mix of corner values, full-range words and words of varied magnitude,
    // so that both saturating and ordinary arithmetic are exercised.
    function automatic t_word random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            case ($urandom_range(4))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        if (pick < 55) return t_word'($urandom);
        return t_word'($signed($urandom) >>> $urandom_range(4, 24));
    endfunction

    // Coefficients are mostly in the range the host would compute, with
    // corner values and full-range words mixed in.
    function automatic t_word random_coef();
        int    pick;
        t_word c;
        pick = $urandom_range(99);
        if (pick < 15) begin
            case ($urandom_range(4))
                0: return WORD_MAX;
                1: return WORD_MIN;
                2: return '0;
                3: return 32'sh8000;
                default: return -32'sh8000;
            endcase
        end
        if (pick < 45) return t_word'($urandom);
        c = t_word'($urandom_range(0, 32'h18000));
        if ($urandom_range(1)) c = -c;
        return c;
    endfunction

    function automatic t_in_item random_voxel();
        t_in_item v;
        v.err_value = random_word();
        v.field_x   = random_word();
        v.field_y   = random_word();
        v.field_z   = random_word();
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // One register write, followed by a cycle with the write enable low so
    // that back-to-back writes never schedule two values in one time step.
    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_GRID_X: size_x_q = val[XY_SIZE_W-1:0];
            CFG_GRID_Y: size_y_q = val[XY_SIZE_W-1:0];
            CFG_GRID_Z: size_z_q = val[Z_SIZE_W-1:0];
            CFG_COEF_X: coef_x_q = t_word'(val);
            CFG_COEF_Y: coef_y_q = t_word'(val);
            CFG_COEF_Z: coef_z_q = t_word'(val);
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_grid(input int nx, input int ny, input int nz);
        write_reg(CFG_GRID_X, DATA_W'(nx));
        write_reg(CFG_GRID_Y, DATA_W'(ny));
        write_reg(CFG_GRID_Z, DATA_W'(nz));
    endtask

    task automatic set_coefs();
        write_reg(CFG_COEF_X, random_coef());
        write_reg(CFG_COEF_Y, random_coef());
        write_reg(CFG_COEF_Z, random_coef());
    endtask

    // Offers one voxel transaction and returns at the edge that accepts it.
    // Valid stays high between back-to-back transactions; it only drops for
    // random idle cycles and in wait_results_done.
    task automatic send_voxel(input t_in_item item);
        while (idle_en && $urandom_range(99) < 31) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_fields.push_back(predict_cleaned_voxel(item));
    endtask

    task automatic stream_grid(input int count);
        repeat (count) send_voxel(random_voxel());
    endtask

    // Stops offering input and waits until every expected result has arrived.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_fields.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The reset configuration is a one-voxel grid with zero coefficients:
    // every voxel passes through and is flagged as the last one.
    task automatic test_reset_passthrough();
        send_voxel('{WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX});
        send_voxel('{WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN});
        wait_results_done();
    endtask

    // In a 2x2x2 grid only the final voxel is cleaned. Its neighbors are set up
    // so that the difference saturates low on the x and y axes and is the lowest
    // word on z, and the sum saturates both high and low.
    task automatic test_saturation();
        t_in_item cube [8];
        set_grid(2, 2, 2);
        write_reg(CFG_COEF_X, WORD_MAX);
        write_reg(CFG_COEF_Y, WORD_MIN);
        write_reg(CFG_COEF_Z, 32'sh10000);
        foreach (cube[i]) cube[i] = random_voxel();
        cube[3].err_value = '0;
        cube[5].err_value = 1;
        cube[6].err_value = WORD_MAX;
        cube[7].err_value = WORD_MIN;
        cube[7].field_x   = WORD_MAX;
        cube[7].field_z   = WORD_MIN;
        foreach (cube[i]) send_voxel(cube[i]);
        wait_results_done();
    endtask

    // Exact halves: +0.5 rounds up to 1, -0.5 rounds up to 0 and -1.5 to -1.
    task automatic test_half_rounding();
        t_in_item cube [8];
        write_reg(CFG_COEF_X, 32'sh8000);
        write_reg(CFG_COEF_Y, 32'sh8000);
        write_reg(CFG_COEF_Z, 32'sh18000);
        foreach (cube[i]) cube[i] = random_voxel();
        cube[3].err_value = 1;
        cube[5].err_value = 1;
        cube[6].err_value = -1;
        cube[7].err_value = '0;
        foreach (cube[i]) send_voxel(cube[i]);
        wait_results_done();
    endtask

    // The grid shrinks along x while the position sits at x = 1. That position
    // is now past the last index, so the next voxel wraps x and advances y,
    // and the grid ends one voxel later. The stores were filled by the cubes
    // above, so no unwritten entry is read.
    task automatic test_resize_mid_grid();
        set_coefs();
        write_reg(CFG_GRID_X, 2);
        stream_grid(5);
        wait_results_done();
        write_reg(CFG_GRID_X, 1);
        stream_grid(2);
        wait_results_done();
    endtask

    // Sizes above their maximum clamp, and zero counts as one. The x case runs
    // a full-width line with cleaning and the y case walks all 256 rows. The
    // z case starts a clamped column, then shrinks it so that the voxel at
    // z = 3 sits past the new last index, ends the grid and wraps to zero.
    task automatic test_size_limits();
        set_grid(9'h1FF, 2, 2);
        set_coefs();
        stream_grid(grid_voxels());
        wait_results_done();
        set_grid(1, 9'd300, 1);
        stream_grid(grid_voxels());
        wait_results_done();
        set_grid(0, 0, 13'h1FFF);
        stream_grid(3);
        wait_results_done();
        write_reg(CFG_GRID_Z, 3);
        stream_grid(1);
        wait_results_done();
        set_grid(0, 0, 0);
        stream_grid(grid_voxels());
        wait_results_done();
    endtask

    // The receiver holds off for a long stretch while voxels keep coming, so
    // the pipeline fills and input stalls. Midway the sender stops until every
    // result is back, then finishes the grid.
    task automatic test_backpressure();
        set_grid(8, 4, 3);
        set_coefs();
        hold_req <= hold_req + 1;
        stream_grid(48);
        wait_results_done();
        stream_grid(48);
        wait_results_done();
    endtask

    // Full rate on both channels with no idle cycles at all.
    task automatic test_steady_stream();
        idle_en <= 1'b0;
        set_grid(16, 4, 3);
        set_coefs();
        stream_grid(grid_voxels());
        wait_results_done();
        idle_en <= 1'b1;
    endtask

    // Mostly small grids with random content, one or two grids per setting.
    task automatic test_random_grids();
        int sent;
        int nx;
        sent = 0;
        while (sent < 250) begin
            nx = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            set_grid(nx, $urandom_range(0, 6), $urandom_range(0, 5));
            set_coefs();
            repeat ($urandom_range(1, 2)) begin
                stream_grid(grid_voxels());
                sent += grid_voxels();
            end
            wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Ready is random while idling is on, held high otherwise, and held low
    // through the HOLD_CYCLES countdown whenever a new hold-off is requested.
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (!idle_en) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 31);
        end
    end

    task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_fields.size() == 0) begin
                mismatches++;
                $display("%0t: output transaction with none expected, got %p",
                         $time, out_data);
            end else begin
                want = expected_fields.pop_front();
                compare_field("new_field_x", want.new_field_x, out_data.new_field_x);
                compare_field("new_field_y", want.new_field_y, out_data.new_field_y);
                compare_field("new_field_z", want.new_field_z, out_data.new_field_z);
                compare_field("last_voxel", DATA_W'(want.last_voxel),
                              DATA_W'(out_data.last_voxel));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     expected_fields.size());
            $display("** div_b_clean_stencil: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_passthrough();
        test_saturation();
        test_half_rounding();
        test_resize_mid_grid();
        test_size_limits();
        test_backpressure();
        test_steady_stream();
        test_random_grids();
        wait_results_done();
        if (mismatches == 0 && expected_fields.size() == 0) begin
            $display("** div_b_clean_stencil: PASSED **");
        end else begin
            $display("** div_b_clean_stencil: FAILED **");
        end
        $finish;
    end

endmodule
